[rtl/accumulator_cpu_8bit_core_unit_macros.svh]
// assertion macros for the cpu core checker
`ifndef ACCUMULATOR_CPU_8BIT_CORE_UNIT_MACROS_SVH
`define ACCUMULATOR_CPU_8BIT_CORE_UNIT_MACROS_SVH

// implication checked on every clock, held off during reset
`define ACU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ACU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/acpu_pkg.sv]
package acpu_pkg;

  localparam int CODE_DEPTH = 2048;
  localparam int RAM_DEPTH  = 256;
  localparam int PC_W       = 11;
  localparam logic [7:0] STACK_BASE_RST = 8'h10;

  localparam logic [1:0] ACT_LOAD_CODE = 2'd0;
  localparam logic [1:0] ACT_WRITE_RAM = 2'd1;
  localparam logic [1:0] ACT_READ_RAM  = 2'd2;
  localparam logic [1:0] ACT_EXEC      = 2'd3;

  localparam logic [3:0] OP_STM   = 4'h0;
  localparam logic [3:0] OP_RET   = 4'h1;
  localparam logic [3:0] OP_MOVI  = 4'h2;
  localparam logic [3:0] OP_MOVIN = 4'h3;
  localparam logic [3:0] OP_LDM   = 4'h4;
  localparam logic [3:0] OP_DJNZ  = 4'h8;
  localparam logic [3:0] OP_SUB   = 4'h9;
  localparam logic [3:0] OP_JNZ   = 4'hA;
  localparam logic [3:0] OP_ADD   = 4'hB;
  localparam logic [3:0] OP_LCALL = 4'hC;
  localparam logic [3:0] OP_POP   = 4'hD;
  localparam logic [3:0] OP_SJMP  = 4'hE;
  localparam logic [3:0] OP_PUSH  = 4'hF;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pc_now;
    logic [7:0]  sp_now;
    logic [3:0]  opcode_done;
    logic [7:0]  reg0_value;
    logic [7:0]  reg1_value;
    logic [7:0]  reg2_value;
    logic [7:0]  reg3_value;
    logic [7:0]  read_data;
  } out_item_t;

endpackage

[rtl/acpu_ram.sv]
module acpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/acpu_queue.sv]
module acpu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acpu_pkg::in_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output acpu_pkg::in_item_t  pop_item,
  output logic                empty
);

  acpu_pkg::in_item_t slot_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

[rtl/acpu_back.sv]
module acpu_back #(
  parameter int CODE_DEPTH = acpu_pkg::CODE_DEPTH,
  parameter int RAM_DEPTH  = acpu_pkg::RAM_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_stack_base,
  input  logic                q_empty,
  input  acpu_pkg::in_item_t  q_item,
  output logic                q_pop,
  output logic                res_valid,
  output acpu_pkg::out_item_t res_item,
  input  logic                res_ready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_F1    = 4'd1;
  localparam logic [3:0] S_F1W   = 4'd2;
  localparam logic [3:0] S_F2W   = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_RD1   = 4'd5;
  localparam logic [3:0] S_RD1W  = 4'd6;
  localparam logic [3:0] S_RD2W  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_CALL2 = 4'd9;
  localparam logic [3:0] S_RAMRW = 4'd10;

  localparam int CA_W = $clog2(CODE_DEPTH);
  localparam int RA_W = $clog2(RAM_DEPTH);

  logic [3:0]  st_r, st_nxt;
  logic [10:0] pc_r, pc_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [7:0]  rf_r [4];
  logic [7:0]  rf_nxt [4];
  logic [7:0]  ir_r, ir_nxt, k_r, k_nxt, hi_r, hi_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [RAM_DEPTH-1:0] vld_r, vld_nxt;
  logic [7:0]  rd_addr_r, rd_addr_nxt;
  logic        ovalid_r, ovalid_nxt;
  acpu_pkg::out_item_t oitem_r, oitem_nxt;

  logic            c_we;
  logic [CA_W-1:0] c_waddr, c_raddr;
  logic [7:0]      c_wdata, c_rdata;
  logic            r_we;
  logic [RA_W-1:0] r_waddr, r_raddr;
  logic [7:0]      r_wdata, r_rdata, ram_val;

  logic [3:0]  op;
  logic [1:0]  rn, rm;
  logic [10:0] ext, pc_br;
  logic [7:0]  dec;

  acpu_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH)) u_code (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );
  acpu_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_data (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata)
  );

  assign ram_val   = vld_r[rd_addr_r[RA_W-1:0]] ? r_rdata : 8'd0;
  assign op        = ir_r[7:4];
  assign rn        = ir_r[1:0];
  assign rm        = ir_r[3:2];
  assign ext       = {{3{k_r[7]}}, k_r};
  assign pc_br     = pc_r + ext;
  assign dec       = rf_r[rn] - 8'd1;
  assign cfg_ready = st_r == S_IDLE;
  assign res_valid = ovalid_r;
  assign res_item  = oitem_r;

  always_comb begin
    st_nxt      = st_r;
    pc_nxt      = pc_r;
    sp_nxt      = sp_r;
    rf_nxt      = rf_r;
    ir_nxt      = ir_r;
    k_nxt       = k_r;
    hi_nxt      = hi_r;
    act_nxt     = act_r;
    vld_nxt     = vld_r;
    rd_addr_nxt = rd_addr_r;
    ovalid_nxt  = ovalid_r && !res_ready;
    oitem_nxt   = oitem_r;
    q_pop       = 1'b0;
    c_we        = 1'b0;
    c_waddr     = q_item.address[CA_W-1:0];
    c_wdata     = q_item.data;
    c_raddr     = pc_r[CA_W-1:0];
    r_we        = 1'b0;
    r_waddr     = q_item.address[RA_W-1:0];
    r_wdata     = q_item.data;
    r_raddr     = rd_addr_r[RA_W-1:0];
    unique case (st_r)
      S_IDLE: begin
        r_raddr = q_item.address[RA_W-1:0];
        if (cfg_valid) begin
          sp_nxt = cfg_stack_base;
        end else if (!q_empty) begin
          q_pop   = 1'b1;
          act_nxt = q_item.action;
          rd_addr_nxt = q_item.address[7:0];
          unique case (q_item.action)
            acpu_pkg::ACT_LOAD_CODE: begin
              c_we   = 1'b1;
              st_nxt = S_DONE;
            end
            acpu_pkg::ACT_WRITE_RAM: begin
              r_we = 1'b1;
              vld_nxt[q_item.address[RA_W-1:0]] = 1'b1;
              st_nxt = S_DONE;
            end
            acpu_pkg::ACT_READ_RAM: st_nxt = S_RAMRW;
            default: begin
              pc_nxt = pc_r + 11'd1;
              st_nxt = S_F1;
            end
          endcase
        end
      end
      S_RAMRW: st_nxt = S_DONE;
      S_F1: begin
        ir_nxt = c_rdata;
        k_nxt  = c_rdata;
        if (!c_rdata[4]) begin
          pc_nxt = pc_r + 11'd1;
          st_nxt = S_F2W;
        end else begin
          st_nxt = S_DEC;
        end
      end
      S_F2W: begin
        k_nxt  = c_rdata;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        st_nxt = S_DONE;
        unique case (op)
          acpu_pkg::OP_STM: begin
            r_we = 1'b1; r_waddr = k_r; r_wdata = rf_r[rn];
            vld_nxt[k_r] = 1'b1;
          end
          acpu_pkg::OP_MOVI: rf_nxt[rn] = k_r;
          acpu_pkg::OP_LDM: begin
            r_raddr = k_r; rd_addr_nxt = k_r; st_nxt = S_RD1;
          end
          acpu_pkg::OP_MOVIN: begin
            r_raddr = rf_r[rm]; rd_addr_nxt = rf_r[rm]; st_nxt = S_RD1;
          end
          acpu_pkg::OP_ADD: rf_nxt[rn] = rf_r[rn] + rf_r[rm];
          acpu_pkg::OP_SUB: rf_nxt[rn] = rf_r[rn] - rf_r[rm];
          acpu_pkg::OP_JNZ: if (rf_r[rn] != 8'd0) pc_nxt = pc_br;
          acpu_pkg::OP_DJNZ: begin
            rf_nxt[rn] = dec;
            if (dec != 8'd0) pc_nxt = pc_br;
          end
          acpu_pkg::OP_PUSH: begin
            r_we = 1'b1; r_waddr = sp_r; r_wdata = rf_r[rn];
            vld_nxt[sp_r] = 1'b1;
            sp_nxt = sp_r + 8'd1;
          end
          acpu_pkg::OP_POP: begin
            sp_nxt = sp_r - 8'd1;
            r_raddr = sp_r - 8'd1; rd_addr_nxt = sp_r - 8'd1; st_nxt = S_RD1;
          end
          acpu_pkg::OP_SJMP: pc_nxt = pc_br;
          acpu_pkg::OP_LCALL: begin
            r_we = 1'b1; r_waddr = sp_r; r_wdata = pc_r[7:0];
            vld_nxt[sp_r] = 1'b1;
            st_nxt = S_CALL2;
          end
          acpu_pkg::OP_RET: begin
            sp_nxt = sp_r - 8'd1;
            r_raddr = sp_r - 8'd1; rd_addr_nxt = sp_r - 8'd1; st_nxt = S_RD1;
          end
          default: ;
        endcase
      end
      S_CALL2: begin
        r_we = 1'b1; r_waddr = sp_r + 8'd1; r_wdata = {5'd0, pc_r[10:8]};
        vld_nxt[sp_r + 8'd1] = 1'b1;
        sp_nxt = sp_r + 8'd2;
        pc_nxt = {ir_r[2:0], k_r};
        st_nxt = S_DONE;
      end
      S_RD1: st_nxt = S_RD1W;
      S_RD1W: begin
        if (op == acpu_pkg::OP_RET) begin
          hi_nxt = ram_val;
          sp_nxt = sp_r - 8'd1;
          r_raddr = sp_r - 8'd1; rd_addr_nxt = sp_r - 8'd1;
          st_nxt = S_RD2W;
        end else begin
          rf_nxt[rn] = ram_val;
          st_nxt = S_DONE;
        end
      end
      S_RD2W: begin
        if (rd_addr_r == sp_r) begin
          st_nxt = S_DONE;
          pc_nxt = {hi_r[2:0], ram_val};
        end else begin
          st_nxt = S_RD2W;
        end
      end
      S_DONE: begin
        if (!ovalid_r || res_ready) begin
          ovalid_nxt = 1'b1;
          oitem_nxt.pc_now = pc_r;
          oitem_nxt.sp_now = sp_r;
          oitem_nxt.opcode_done = (act_r == acpu_pkg::ACT_EXEC) ? op : 4'd0;
          oitem_nxt.reg0_value = rf_r[0];
          oitem_nxt.reg1_value = rf_r[1];
          oitem_nxt.reg2_value = rf_r[2];
          oitem_nxt.reg3_value = rf_r[3];
          oitem_nxt.read_data = (act_r == acpu_pkg::ACT_READ_RAM) ? ram_val : 8'd0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pc_r     <= '0;
      sp_r     <= acpu_pkg::STACK_BASE_RST;
      rf_r     <= '{default: 8'd0};
      vld_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pc_r     <= pc_nxt;
      sp_r     <= sp_nxt;
      rf_r     <= rf_nxt;
      vld_r    <= vld_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ir_r      <= ir_nxt;
    k_r       <= k_nxt;
    hi_r      <= hi_nxt;
    act_r     <= act_nxt;
    rd_addr_r <= rd_addr_nxt;
    oitem_r   <= oitem_nxt;
  end

endmodule

[rtl/accumulator_cpu_8bit_core_unit.sv]
// 8-bit cpu core. each request loads a code byte, writes or reads a data ram byte, or
// runs one instruction, and returns one result with pc, sp and registers. a two-entry
// queue takes requests while the execute sequencer works; code loads and ram writes go
// straight to done, ram reads wait on the registered data ram, and an instruction fetches
// through the registered code store, decodes and may read the data ram. a result waits in
// an output register while the next request starts. stack_base writes load sp when idle.
module accumulator_cpu_8bit_core_unit #(
  parameter int CODE_DEPTH = acpu_pkg::CODE_DEPTH,
  parameter int RAM_DEPTH  = acpu_pkg::RAM_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acpu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output acpu_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic q_full, q_empty, q_pop;
  acpu_pkg::in_item_t q_item;

  assign in_ready = !q_full;

  acpu_queue u_queue (
    .clk, .rst_n, .push(in_valid && !q_full), .push_item(in_item), .full(q_full),
    .pop(q_pop), .pop_item(q_item), .empty(q_empty)
  );

  acpu_back #(.CODE_DEPTH(CODE_DEPTH), .RAM_DEPTH(RAM_DEPTH)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_stack_base(cfg_data),
    .q_empty, .q_item, .q_pop, .res_valid(out_valid), .res_item(out_item),
    .res_ready(out_ready)
  );

endmodule

[rtl/acpu_checker.sv]
`include "accumulator_cpu_8bit_core_unit_macros.svh"

module acpu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input acpu_pkg::out_item_t out_item,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  `ACU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  `ACU_ASSERT_IMP(a_rd_zero, out_valid && out_item.opcode_done != 4'd0, out_item.read_data == 8'd0)
  `ACU_ASSERT_NXT(a_cfg_sp, cfg_valid && cfg_ready, !out_valid || !$rose(out_valid))
  `ACU_ASSERT_NXT(a_reset_idle, !rst_n, !out_valid)

endmodule

bind accumulator_cpu_8bit_core_unit acpu_checker u_acpu_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_item,
  .cfg_valid, .cfg_ready
);
